// ----- hw/rtl/c16am_pkg.sv -----
// c16am_pkg: widths, register indexes, reset values and crc step functions
// for the crc16 augmented-message unit; no dependencies

package c16am_pkg;

  localparam int CRC_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0] INIT_RST = 16'hFFFF;
  localparam logic [CRC_W-1:0] POLY_RST = 16'h1021;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_VALUE = 1'b0,
    CFG_POLYNOMIAL = 1'b1
  } cfg_reg_t;

  // eight bit steps, msb first into the low end, poly xored on carry out
  function automatic crc_t shift_byte(crc_t crc_in, byte_t data, crc_t poly);
    crc_t acc;
    acc = crc_in;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (acc[CRC_W-1]) begin
        acc = {acc[CRC_W-2:0], data[i]} ^ poly;
      end else begin
        acc = {acc[CRC_W-2:0], data[i]};
      end
    end
    return acc;
  endfunction

  function automatic crc_t swap_bytes(crc_t v);
    return {v[BYTE_W-1:0], v[CRC_W-1:BYTE_W]};
  endfunction

endpackage

// ----- hw/rtl/c16am_in_if.sv -----
// c16am_in_if: input channel of the crc16 augmented-message unit
// depends on c16am_pkg

interface c16am_in_if import c16am_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/c16am_out_if.sv -----
// c16am_out_if: result channel of the crc16 augmented-message unit
// depends on c16am_pkg

interface c16am_out_if import c16am_pkg::*;;
  logic valid;
  logic ready;
  crc_t crc_swapped;

  modport source (output valid, output crc_swapped, input ready);
  modport sink   (input valid, input crc_swapped, output ready);
endinterface

// ----- hw/rtl/crc16_augmented_message_unit.sv -----
// crc16_augmented_message_unit: crc16 over a byte stream, augmented-message
// method, with a 16-bit zero flush and byte swap on the last byte
// depends on c16am_pkg, c16am_in_if, c16am_out_if
//
//   channel  direction  payload                   handshake
//   in_ch    sink       data_byte[7:0], last_byte valid / ready
//   out_ch   source     crc_swapped[15:0]         valid / ready
//   cfg_*    sink       cfg_index, cfg_wdata      cfg_we, no stall
//
// one byte accepted per cycle unless a last byte waits in the input register for
// the flush stages; the running crc is loaded from the input register by an
// eight-step xor network; a last byte then passes s1, s2 and the output register,
// the 16-bit flush running as two 8-step stages ahead of the output register
// out stalls back up the flush stages; bytes that are not last keep moving
// reset (rst_n low, synchronous) empties all stages and loads the registers
// with init 0xFFFF and polynomial 0x1021

module crc16_augmented_message_unit import c16am_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]     cfg_wdata,
  c16am_in_if.sink             in_ch,
  c16am_out_if.source          out_ch
);

  crc_t  init_r;
  crc_t  poly_r;

  logic  s0_vld_r;
  byte_t s0_data_r;
  logic  s0_last_r;

  crc_t  crc_r;
  logic  start_r;

  logic  s1_vld_r;
  crc_t  s1_crc_r;
  logic  s2_vld_r;
  crc_t  s2_crc_r;
  logic  out_vld_r;
  crc_t  out_crc_r;

  logic  out_free;
  logic  s2_free;
  logic  s1_free;
  logic  s0_adv;
  logic  in_rdy;
  crc_t  byte_crc;

  assign out_free = !out_vld_r || out_ch.ready;
  assign s2_free  = !s2_vld_r || out_free;
  assign s1_free  = !s1_vld_r || s2_free;
  assign s0_adv   = s0_vld_r && (!s0_last_r || s1_free);
  assign in_rdy   = !s0_vld_r || s0_adv;

  assign byte_crc = shift_byte(start_r ? init_r : crc_r, s0_data_r, poly_r);

  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.crc_swapped = out_crc_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= INIT_RST;
      poly_r <= POLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INIT_VALUE: init_r <= cfg_wdata;
        CFG_POLYNOMIAL: poly_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_rdy) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      s0_data_r <= in_ch.data_byte;
      s0_last_r <= in_ch.last_byte;
    end
  end

  // running crc and message start flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      start_r <= 1'b1;
    end else if (s0_adv) begin
      crc_r   <= byte_crc;
      start_r <= s0_last_r;
    end
  end

  // flush pipeline, only last bytes enter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_r <= s0_adv && s0_last_r;
      end
      if (s2_free) begin
        s2_vld_r <= s1_vld_r;
      end
      if (out_free) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_crc_r <= byte_crc;
    end
    if (s2_free) begin
      s2_crc_r <= shift_byte(s1_crc_r, '0, poly_r);
    end
    if (out_free) begin
      out_crc_r <= swap_bytes(shift_byte(s2_crc_r, '0, poly_r));
    end
  end

endmodule

// ----- hw/rtl/c16am_checker.sv -----
// c16am_checker: port-level assertions for crc16_augmented_message_unit
// depends on c16am_pkg; bound to crc16_augmented_message_unit below

module c16am_checker import c16am_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input crc_t out_crc
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_crc))
    else $error("result dropped or changed while stalled");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // a draining output never stalls the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // a last byte reaches the output when the output keeps draining after acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("result for last item missing");

endmodule

bind crc16_augmented_message_unit c16am_checker u_c16am_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_crc   (out_ch.crc_swapped)
);

// ----- bench/crc16_check.sv -----
`timescale 1ns / 100ps
// crc16_check: watches the ports of the crc16 augmented-message unit, predicts
// every crc result from the accepted bytes and compares it with the unit's output
// depends on c16am_pkg, c16am_in_if and c16am_out_if

module crc16_check import c16am_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]     cfg_wdata,
  c16am_in_if                  in_ch,
  c16am_out_if                 out_ch,
  output int                   crc_pending,
  output int                   mismatch_count
);

  crc_t crc_due_q[$];
  crc_t init_copy;
  crc_t poly_copy;
  crc_t run_crc;
  logic at_msg_start;

  function automatic crc_t crc_feed_bit(crc_t crc, logic bit_in, crc_t poly);
    crc_t nxt;
    nxt = {crc[CRC_W-2:0], bit_in};
    if (crc[CRC_W-1]) begin
      nxt = nxt ^ poly;
    end
    return nxt;
  endfunction

  always @(posedge clk) begin
    crc_t acc;
    crc_t want;
    int   errs;
    if (!rst_n) begin
      crc_due_q.delete();
      init_copy = INIT_RST;
      poly_copy = POLY_RST;
      run_crc = '0;
      at_msg_start = 1'b1;
      crc_pending <= 0;
      mismatch_count <= 0;
    end else begin
      errs = mismatch_count;
      if (out_ch.valid && out_ch.ready) begin
        if (crc_due_q.size() == 0) begin
          $display("%0t crc16_check: crc_swapped %04h given with no item pending",
                   $time, out_ch.crc_swapped);
          errs++;
        end else begin
          want = crc_due_q.pop_front();
          if (out_ch.crc_swapped !== want) begin
            $display("%0t crc16_check: crc_swapped expected %04h actual %04h",
                     $time, want, out_ch.crc_swapped);
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        acc = at_msg_start ? init_copy : run_crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
          acc = crc_feed_bit(acc, in_ch.data_byte[i], poly_copy);
        end
        if (in_ch.last_byte) begin
          // augmented flush: sixteen zero bits
          for (int i = 0; i < CRC_W; i++) begin
            acc = crc_feed_bit(acc, 1'b0, poly_copy);
          end
          crc_due_q.push_back({acc[BYTE_W-1:0], acc[CRC_W-1:BYTE_W]});
        end
        run_crc = acc;
        at_msg_start = in_ch.last_byte;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_INIT_VALUE: init_copy = cfg_wdata;
          CFG_POLYNOMIAL: poly_copy = cfg_wdata;
          default: ;
        endcase
      end
      crc_pending <= crc_due_q.size();
      mismatch_count <= errs;
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// tb: drives byte messages and register settings into the crc16 augmented-message
// unit with random gaps and result stalls; crc16_check does the comparison
// depends on c16am_pkg, c16am_in_if, c16am_out_if, crc16_check and the unit

module tb import c16am_pkg::*;;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES   = 115;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  crc_t                 cfg_wdata;
  int                   crc_pending;
  int                   mismatch_count;
  int                   cycle_count = 0;
  int                   send_calm = 0;
  int                   take_calm = 0;

  c16am_in_if  in_ch();
  c16am_out_if out_ch();

  crc16_augmented_message_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  crc16_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .crc_pending    (crc_pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // wait cycles before the next item, with runs of back-to-back items
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic int msg_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return $urandom_range(1, 4);
    end else if (r < 9) begin
      return $urandom_range(5, 20);
    end
    return $urandom_range(21, 80);
  endfunction

  task automatic send_byte(input byte_t data, input logic last);
    int gap;
    gap = draw_wait(send_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    int    pattern;
    byte_t b;
    pattern = $urandom_range(0, 9);
    for (int k = 1; k <= len; k++) begin
      case (pattern)
        0:       b = '0;
        1:       b = '1;
        default: b = byte_t'($urandom_range(0, 255));
      endcase
      send_byte(b, k == len);
    end
  endtask

  // stop sending, wait out every pending crc and the flush stages
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (crc_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input crc_t init_val, input crc_t poly_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INIT_VALUE;
    cfg_wdata <= init_val;
    @(posedge clk);
    cfg_index <= CFG_POLYNOMIAL;
    cfg_wdata <= poly_val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int stall;
    forever begin
      stall = draw_wait(take_calm);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  initial begin
    int   phase_bytes;
    int   len;
    crc_t iv;
    crc_t pv;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_INIT_VALUE;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte messages on reset settings
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    // ascii 1..9 as one message
    for (int k = 1; k <= 9; k++) begin
      send_byte(byte_t'(8'h30 + k), k == 9);
    end
    settle();

    set_regs(16'h1D0F, 16'h8005);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       begin iv = 16'hFFFF; pv = 16'h0000; end
        1:       begin iv = 16'h0000; pv = 16'hFFFF; end
        2:       begin iv = 16'hFFFF; pv = 16'hFFFF; end
        3:       begin iv = 16'h0000; pv = 16'h0000; end
        4:       begin iv = INIT_RST; pv = POLY_RST; end
        default: begin
          iv = crc_t'($urandom_range(0, 65535));
          pv = crc_t'($urandom_range(0, 65535));
        end
      endcase
      set_regs(iv, pv);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        len = msg_len();
        send_message(len);
        phase_bytes += len;
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- crc16_augmented_message_unit.f -----
hw/rtl/c16am_pkg.sv
hw/rtl/c16am_in_if.sv
hw/rtl/c16am_out_if.sv
hw/rtl/crc16_augmented_message_unit.sv
hw/rtl/c16am_checker.sv
bench/crc16_check.sv
bench/tb.sv
